// ===== hw/rtl/tam_pkg.sv =====
// shared types and constants for the triangulation alpha matte pipeline
`default_nettype none
package tam_pkg;

	localparam int PIX_W        = 8;
	localparam int CHAN         = 3;
	localparam int DIFF_W       = PIX_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int SQ_W         = 2 * PIX_W;
	localparam int NUM_W        = PROD_W + 1;
	localparam int DEN_W        = SQ_W + 2;
	localparam int TOP_W        = NUM_W + 1;
	localparam int Q_W          = 8;
	localparam int REM_W        = DEN_W + Q_W;
	localparam int DSH_W        = DEN_W + Q_W - 1;
	localparam int FRONT_STAGES = 4;
	localparam int PIPE_DEPTH   = FRONT_STAGES + Q_W + 1;
	localparam int CNT_W        = $clog2(PIPE_DEPTH + 1);

	localparam logic [Q_W-1:0] ALPHA_ZERO = '0;
	localparam logic [Q_W-1:0] ALPHA_FULL = Q_W'(255);

	typedef struct packed {
		logic [PIX_W-1:0] comp1_ch0;
		logic [PIX_W-1:0] comp1_ch1;
		logic [PIX_W-1:0] comp1_ch2;
		logic [PIX_W-1:0] comp2_ch0;
		logic [PIX_W-1:0] comp2_ch1;
		logic [PIX_W-1:0] comp2_ch2;
		logic [PIX_W-1:0] back1_ch0;
		logic [PIX_W-1:0] back1_ch1;
		logic [PIX_W-1:0] back1_ch2;
		logic [PIX_W-1:0] back2_ch0;
		logic [PIX_W-1:0] back2_ch1;
		logic [PIX_W-1:0] back2_ch2;
	} in_item_t;

	typedef struct packed {
		logic [Q_W-1:0] alpha_gray;
		logic           degenerate;
	} out_item_t;

	// partial division state handed from stage to stage
	typedef struct packed {
		logic             degenerate;
		logic             fixed;
		logic [Q_W-1:0]   quo;
		logic [REM_W-1:0] rem;
		logic [DSH_W-1:0] dsh;
	} div_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/triangulation_alpha_matte_top.sv =====
// top level of the triangulation alpha matte pipeline
// usage:
//   one request on the input channel carries the co-located pixel of two
//   composites and their two backgrounds, three 8-bit channels each
//   one request on the output channel carries alpha_gray = floor(255*alpha)
//   and the degenerate flag (backgrounds equal, alpha forced to 0)
//   both channels are valid/ready; a request moves when valid and ready are high
// timing:
//   a request passes through 13 register stages from input accept to output:
//   4 front stages, 8 divider stages (one quotient bit each), 1 output register
//   throughput is one request per cycle while the output is not stalled, set by the fully pipelined divider
// reset:
//   arst_n clears every valid bit at once; payload registers are not reset
// stall:
//   each stage holds while the one after it is full and stalled, so bubbles
//   collapse and input keeps being taken until all 13 stages hold a request
`default_nettype none
module triangulation_alpha_matte_top
	import tam_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	// handshake chain through the divider stages, index 0 is the front output
	logic      dv   [Q_W+1];
	logic      dr   [Q_W+1];
	div_item_t ditem [Q_W+1];

	logic      out_v_q;
	out_item_t out_item_q;
	logic      out_en;

	// differences, products, sums and clamp decision
	tam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (dv[0]),
		.out_ready (dr[0]),
		.out_data  (ditem[0])
	);

	// quotient bits from msb down, one per stage
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		tam_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in_data   (ditem[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out_data  (ditem[k+1])
		);
	end

	// output register parts the divider from the receiver
	assign out_en   = !out_v_q || out_ready;
	assign dr[Q_W]  = out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= dv[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_item_q.alpha_gray <= ditem[Q_W].quo;
			out_item_q.degenerate <= ditem[Q_W].degenerate;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_item_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tam_front.sv =====
// front stages: differences, products, sums, clamp decision and dividend
`default_nettype none
module tam_front
	import tam_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output div_item_t      out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [DIFF_W-1:0] db_c [CHAN];
	logic signed [DIFF_W-1:0] dc_c [CHAN];
	logic signed [DIFF_W-1:0] db_s1 [CHAN];
	logic signed [DIFF_W-1:0] dc_s1 [CHAN];
	logic signed [PROD_W-1:0] pp_s2 [CHAN];
	logic signed [PROD_W-1:0] sq_s2 [CHAN];
	logic signed [NUM_W-1:0]  num_s3;
	logic        [DEN_W-1:0]  den_s3;
	logic signed [NUM_W-1:0]  den_sx;
	logic signed [TOP_W-1:0]  top_c;
	div_item_t                prep_c;
	div_item_t                item_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	function automatic logic signed [DIFF_W-1:0] diff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	always_comb begin
		db_c[0] = diff(in_data.back2_ch0, in_data.back1_ch0);
		db_c[1] = diff(in_data.back2_ch1, in_data.back1_ch1);
		db_c[2] = diff(in_data.back2_ch2, in_data.back1_ch2);
		dc_c[0] = diff(in_data.comp2_ch0, in_data.comp1_ch0);
		dc_c[1] = diff(in_data.comp2_ch1, in_data.comp1_ch1);
		dc_c[2] = diff(in_data.comp2_ch2, in_data.comp1_ch2);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int c = 0; c < CHAN; c++) begin
				db_s1[c] <= db_c[c];
				dc_s1[c] <= dc_c[c];
			end
		end
		if (en_s2) begin
			for (int c = 0; c < CHAN; c++) begin
				pp_s2[c] <= PROD_W'(db_s1[c]) * PROD_W'(dc_s1[c]);
				sq_s2[c] <= PROD_W'(db_s1[c]) * PROD_W'(db_s1[c]);
			end
		end
		if (en_s3) begin
			num_s3 <= NUM_W'(pp_s2[0]) + NUM_W'(pp_s2[1]) + NUM_W'(pp_s2[2]);
			den_s3 <= DEN_W'(sq_s2[0][SQ_W-1:0]) + DEN_W'(sq_s2[1][SQ_W-1:0])
				+ DEN_W'(sq_s2[2][SQ_W-1:0]);
		end
		if (en_s4) item_s4 <= prep_c;
	end

	// clamp cases resolve here, the rest goes on to the divider
	always_comb begin
		den_sx = $signed({1'b0, den_s3});
		top_c  = TOP_W'(den_sx) - TOP_W'(num_s3);
		prep_c.degenerate = 1'b0;
		prep_c.fixed      = 1'b0;
		prep_c.quo        = ALPHA_ZERO;
		prep_c.rem        = REM_W'({top_c[DEN_W-1:0], 8'b0}) - REM_W'(top_c[DEN_W-1:0]);
		prep_c.dsh        = DSH_W'({den_s3, (Q_W-1)'(0)});
		if (den_s3 == '0) begin
			prep_c.degenerate = 1'b1;
			prep_c.fixed      = 1'b1;
		end else if (num_s3 >= den_sx) begin
			prep_c.fixed      = 1'b1;
		end else if (num_s3[NUM_W-1] || num_s3 == '0) begin
			// num not above zero
			prep_c.fixed      = 1'b1;
			prep_c.quo        = ALPHA_FULL;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = item_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/tam_div_step.sv =====
// one restoring division step, one quotient bit per stage
`default_nettype none
module tam_div_step
	import tam_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire div_item_t in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output div_item_t      out_data
);

	logic             v_s1;
	div_item_t        item_s1;
	div_item_t        next_c;
	logic [REM_W-1:0] sub_c;
	logic             fit_c;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		sub_c  = REM_W'(in_data.dsh);
		fit_c  = in_data.rem >= sub_c;
		next_c = in_data;
		next_c.dsh = in_data.dsh >> 1;
		if (!in_data.fixed) begin
			next_c.quo = {in_data.quo[Q_W-2:0], fit_c};
			if (fit_c) next_c.rem = in_data.rem - sub_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) item_s1 <= next_c;
	end

	assign out_valid = v_s1;
	assign out_data  = item_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/tam_checker.sv =====
// port-level checker for the triangulation alpha matte top, with its bind
`default_nettype none
module tam_checker
	import tam_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	logic [CNT_W-1:0] pend_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// requests inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output request changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.alpha_gray == ALPHA_ZERO)
		else $error("degenerate request with nonzero alpha");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("output request with none pending");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(PIPE_DEPTH))
		else $error("more requests pending than pipeline stages");

endmodule

bind triangulation_alpha_matte_top tam_checker u_tam_checker (.*);
`default_nettype wire
